@@ sv/ssb_pkg.sv @@
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared constants and the per-item control bundle of the swept sphere test.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int AXES = 3;

  // Control bits that travel beside the divider pipeline.
  typedef struct packed {
    logic            valid;
    logic            zero_len;
    logic            par_miss;
    logic [AXES-1:0] flat;
  } ctrl_t;

endpackage

@@ sv/ssb_prep.sv @@
// ----------------------------------------------------------------------------
// ssb_prep
// Two front stages: grown and ungrown box bounds in doubled units, then the
// slab numerators, denominators and the closest-point deltas.
// ----------------------------------------------------------------------------
module ssb_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] sx     [ssb_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] ex     [ssb_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] cx     [ssb_pkg::AXES],
  input  logic        [COORD_WIDTH-2:0] ext    [ssb_pkg::AXES],
  input  logic        [COORD_WIDTH-2:0] radius,
  output ssb_pkg::ctrl_t                ctrl,
  output logic signed [COORD_WIDTH+3:0] num_en [ssb_pkg::AXES],
  output logic signed [COORD_WIDTH+3:0] num_ex [ssb_pkg::AXES],
  output logic signed [COORD_WIDTH+3:0] den    [ssb_pkg::AXES],
  output logic        [COORD_WIDTH+2:0] delta  [ssb_pkg::AXES],
  output logic        [COORD_WIDTH-1:0] r2
);
  import ssb_pkg::*;

  localparam int W = COORD_WIDTH + 4;

  logic signed [W-1:0] a_o2  [AXES];
  logic signed [W-1:0] a_d   [AXES];
  logic signed [W-1:0] a_lou [AXES];
  logic signed [W-1:0] a_hiu [AXES];
  logic signed [W-1:0] a_log [AXES];
  logic signed [W-1:0] a_hig [AXES];
  logic [COORD_WIDTH-1:0] a_r2;
  logic a_valid;

  always_ff @(posedge clk) begin
    logic signed [W-1:0] c2, extw, r2w, lou, hiu;
    r2w = W'({radius, 1'b0});
    for (int a = 0; a < AXES; a++) begin
      c2   = W'(cx[a]) <<< 1;
      extw = W'(ext[a]);
      lou  = c2 - extw;
      hiu  = c2 + extw;
      a_o2[a]  <= W'(sx[a]) <<< 1;
      a_d[a]   <= W'(ex[a]) - W'(sx[a]);
      a_lou[a] <= lou;
      a_hiu[a] <= hiu;
      a_log[a] <= lou - r2w;
      a_hig[a] <= hiu + r2w;
    end
    a_r2 <= {radius, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W-1:0] nlo, nhi, dl;
    logic flat_n;
    logic miss_n;
    miss_n = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      nlo = a_log[a] - a_o2[a];
      nhi = a_hig[a] - a_o2[a];
      flat_n = (a_d[a] == '0);
      if (a_d[a][W-1]) begin
        num_en[a] <= nhi;
        num_ex[a] <= nlo;
      end else begin
        num_en[a] <= nlo;
        num_ex[a] <= nhi;
      end
      den[a] <= a_d[a] <<< 1;
      if (flat_n && (a_o2[a] < a_log[a] || a_o2[a] > a_hig[a])) begin
        miss_n = 1'b1;
      end
      if (a_o2[a] < a_lou[a]) begin
        dl = a_lou[a] - a_o2[a];
      end else if (a_o2[a] > a_hiu[a]) begin
        dl = a_o2[a] - a_hiu[a];
      end else begin
        dl = '0;
      end
      delta[a] <= dl[W-2:0];
      ctrl.flat[a] <= flat_n;
    end
    ctrl.par_miss <= miss_n;
    ctrl.zero_len <= (a_d[0] == '0) && (a_d[1] == '0) && (a_d[2] == '0);
    r2 <= a_r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= a_valid;
    end
  end

endmodule

@@ sv/ssb_div.sv @@
// ----------------------------------------------------------------------------
// ssb_div
// Pipelined restoring divider for one slab parameter, one quotient bit per
// stage, with the below-zero and beyond-one codes resolved up front.
// ----------------------------------------------------------------------------
module ssb_div #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic signed [COORD_WIDTH+3:0]   num,
  input  logic signed [COORD_WIDTH+3:0]   den,
  output logic signed [FRACTION_BITS+2:0] param
);
  localparam int W  = COORD_WIDTH + 4;
  localparam int F  = FRACTION_BITS;
  localparam int PW = FRACTION_BITS + 3;

  logic [W-2:0] rem  [F+2];
  logic [W-2:0] ud   [F+2];
  logic [F:0]   q    [F+2];
  logic         neg  [F+2];
  logic         over [F+2];

  always_ff @(posedge clk) begin
    logic [W-1:0] un_w, ud_w;
    logic neg_n, over_n;
    un_w   = num[W-1] ? W'(-num) : W'(num);
    ud_w   = den[W-1] ? W'(-den) : W'(den);
    neg_n  = (num != '0) && (num[W-1] != den[W-1]);
    over_n = !neg_n && (un_w > ud_w);
    rem[0]  <= (neg_n || over_n) ? '0 : un_w[W-2:0];
    ud[0]   <= ud_w[W-2:0];
    q[0]    <= '0;
    neg[0]  <= neg_n;
    over[0] <= over_n;
  end

  for (genvar i = 0; i <= F; i++) begin : g_step
    logic [W-1:0] t;
    logic         qb;
    if (i == 0) begin : g_first
      assign t = {1'b0, rem[i]};
    end else begin : g_rest
      assign t = {rem[i], 1'b0};
    end
    assign qb = (t >= {1'b0, ud[i]});

    always_ff @(posedge clk) begin
      logic [W-1:0] diff;
      diff = t - {1'b0, ud[i]};
      rem[i+1]  <= qb ? diff[W-2:0] : t[W-2:0];
      ud[i+1]   <= ud[i];
      q[i+1]    <= {q[i][F-1:0], qb};
      neg[i+1]  <= neg[i];
      over[i+1] <= over[i];
    end
  end

  always_comb begin
    if (neg[F+1]) begin
      param = '1;
    end else if (over[F+1]) begin
      param = (PW'(1) << F) + PW'(1);
    end else begin
      param = {2'b00, q[F+1]};
    end
  end

endmodule

@@ sv/ssb_sphere.sv @@
// ----------------------------------------------------------------------------
// ssb_sphere
// Static sphere against the ungrown box: squared closest-point distance
// against the squared radius, then delayed to line up with the slab path.
// ----------------------------------------------------------------------------
module ssb_sphere #(
  parameter int COORD_WIDTH = 32,
  parameter int DEPTH       = 18
) (
  input  logic                   clk,
  input  logic [COORD_WIDTH+2:0] delta [ssb_pkg::AXES],
  input  logic [COORD_WIDTH-1:0] r2,
  output logic                   ok
);
  import ssb_pkg::*;

  localparam int C = COORD_WIDTH;

  logic [C-1:0]   s1_ad [AXES];
  logic [C-1:0]   s1_r2;
  logic           s1_far;
  logic [2*C-1:0] s2_sq [AXES];
  logic [2*C-1:0] s2_lim;
  logic           s2_far;
  logic           okd   [DEPTH-2];

  always_ff @(posedge clk) begin
    logic far_n;
    far_n = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (delta[a] > (C+3)'(r2)) begin
        far_n = 1'b1;
      end
      s1_ad[a] <= delta[a][C-1:0];
    end
    s1_far <= far_n;
    s1_r2  <= r2;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      s2_sq[a] <= s1_ad[a] * s1_ad[a];
    end
    s2_lim <= s1_r2 * s1_r2;
    s2_far <= s1_far;
  end

  always_ff @(posedge clk) begin
    logic [2*C+1:0] sum;
    sum = (2*C+2)'(s2_sq[0]) + (2*C+2)'(s2_sq[1]) + (2*C+2)'(s2_sq[2]);
    okd[0] <= !s2_far && (sum <= (2*C+2)'(s2_lim));
  end

  for (genvar k = 0; k < DEPTH - 3; k++) begin : g_dly
    always_ff @(posedge clk) begin
      okd[k+1] <= okd[k];
    end
  end

  assign ok = okd[DEPTH-3];

endmodule

@@ sv/swept_sphere_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// swept_sphere_box_slab_test
// Swept sphere against an axis-aligned box by slab clipping.
// ----------------------------------------------------------------------------
// Usage:
//   An item (segment start, end, box center and full size) is taken at a
//   rising edge with start high and busy low. busy is high only during reset,
//   so one item can be taken in every cycle.
//   Each item gives one result: hit and entry_fraction appear for exactly one
//   cycle with done high, after the prep stages, the divider pipeline and the
//   output register. The six slab divisions run in parallel restoring
//   dividers of one quotient bit per stage, which make up most of the pipeline.
//   Throughput is one item per cycle.
//   The user writes the sphere radius over cfg_valid/cfg_ready/cfg_data only
//   while no item is in flight (not enforced); cfg_ready is always high.
//   Reset is synchronous: it clears the pipeline valid bits, drops any item
//   in flight and sets the radius to 1.0. The receiver cannot stall, so no
//   back pressure exists.
// ----------------------------------------------------------------------------
module swept_sphere_box_slab_test #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-2:0] extent_x,
  input  logic        [COORD_WIDTH-2:0] extent_y,
  input  logic        [COORD_WIDTH-2:0] extent_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [COORD_WIDTH-2:0] cfg_data,
  output logic                          done,
  output logic                          hit,
  output logic        [FRACTION_BITS:0] entry_fraction
);
  import ssb_pkg::*;

  localparam int C            = COORD_WIDTH;
  localparam int F            = FRACTION_BITS;
  localparam int W            = COORD_WIDTH + 4;
  localparam int PW           = FRACTION_BITS + 3;
  localparam int DIV_LAT      = FRACTION_BITS + 2;
  localparam int LAT          = FRACTION_BITS + 5;
  localparam int RADIUS_RESET = 65536;

  logic [C-2:0] radius;
  logic         in_valid;

  logic signed [C-1:0] sx  [AXES];
  logic signed [C-1:0] ex  [AXES];
  logic signed [C-1:0] cx  [AXES];
  logic        [C-2:0] ext [AXES];

  ctrl_t               ctrl_b;
  ctrl_t               cl     [DIV_LAT+1];
  logic signed [W-1:0] num_en [AXES];
  logic signed [W-1:0] num_ex [AXES];
  logic signed [W-1:0] den    [AXES];
  logic        [W-2:0] delta  [AXES];
  logic        [C-1:0] r2;
  logic signed [PW-1:0] ten   [AXES];
  logic signed [PW-1:0] tex   [AXES];
  logic                sph_ok;

  logic         hit_next;
  logic [F:0]   frac_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= (C-1)'(RADIUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  assign sx[0]  = start_x;
  assign sx[1]  = start_y;
  assign sx[2]  = start_z;
  assign ex[0]  = end_x;
  assign ex[1]  = end_y;
  assign ex[2]  = end_z;
  assign cx[0]  = center_x;
  assign cx[1]  = center_y;
  assign cx[2]  = center_z;
  assign ext[0] = extent_x;
  assign ext[1] = extent_y;
  assign ext[2] = extent_z;

  ssb_prep #(.COORD_WIDTH(C)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sx       (sx),
    .ex       (ex),
    .cx       (cx),
    .ext      (ext),
    .radius   (radius),
    .ctrl     (ctrl_b),
    .num_en   (num_en),
    .num_ex   (num_ex),
    .den      (den),
    .delta    (delta),
    .r2       (r2)
  );

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    ssb_div #(.COORD_WIDTH(C), .FRACTION_BITS(F)) u_div_en (
      .clk   (clk),
      .num   (num_en[a]),
      .den   (den[a]),
      .param (ten[a])
    );
    ssb_div #(.COORD_WIDTH(C), .FRACTION_BITS(F)) u_div_ex (
      .clk   (clk),
      .num   (num_ex[a]),
      .den   (den[a]),
      .param (tex[a])
    );
  end

  ssb_sphere #(.COORD_WIDTH(C), .DEPTH(DIV_LAT)) u_sphere (
    .clk   (clk),
    .delta (delta),
    .r2    (r2),
    .ok    (sph_ok)
  );

  assign cl[0] = ctrl_b;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_ctrl
    always_ff @(posedge clk) begin
      if (rst) begin
        cl[k+1] <= '0;
      end else begin
        cl[k+1] <= cl[k];
      end
    end
  end

  // Running max of entry and min of exit; flat axes do not restrict t.
  always_comb begin
    logic signed [PW-1:0] tmin, tmax;
    logic slab_hit;
    tmin = '0;
    tmax = PW'(1) << F;
    for (int a = 0; a < AXES; a++) begin
      if (!cl[DIV_LAT].flat[a]) begin
        if (ten[a] > tmin) begin
          tmin = ten[a];
        end
        if (tex[a] < tmax) begin
          tmax = tex[a];
        end
      end
    end
    slab_hit  = !cl[DIV_LAT].par_miss && (tmin <= tmax);
    hit_next  = cl[DIV_LAT].zero_len ? sph_ok : slab_hit;
    frac_next = (!cl[DIV_LAT].zero_len && slab_hit) ? tmin[F:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cl[DIV_LAT].valid;
    end
  end

  always_ff @(posedge clk) begin
    hit            <= hit_next;
    entry_fraction <= frac_next;
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> entry_fraction == '0)
    else $error("entry fraction nonzero on a miss");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> entry_fraction <= ((F+1)'(1) << F))
    else $error("entry fraction above one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(LAT) done)
    else $error("item accepted without a result at the pipeline depth");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");
`endif

endmodule
